// ----- src/stopwatch_seven_segment_mux_defines.svh -----
// Assertion helpers shared by the stopwatch RTL.
`ifndef STOPWATCH_SEVEN_SEGMENT_MUX_DEFINES_SVH
`define STOPWATCH_SEVEN_SEGMENT_MUX_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SWSSM_ASSERT_NOW(name, clk_i, rstn_i, ante, cons) \
    name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("swssm: assertion failed");

// Check cons in the cycle after ante.
`define SWSSM_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons) \
    name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("swssm: assertion failed");

`endif

// ----- src/swssm_pkg.sv -----
package swssm_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int CNT_W      = 14;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SCAN = 2'd1;
    localparam logic [1:0] OP_DATE = 2'd2;

    localparam logic [2:0] REG_WRAP_LIMIT         = 3'd0;
    localparam logic [2:0] REG_BLINK_PERIOD       = 3'd1;
    localparam logic [2:0] REG_DEBOUNCE_STEPS     = 3'd2;
    localparam logic [2:0] REG_DATE_PHASE_TICKS   = 3'd3;
    localparam logic [2:0] REG_DATE_DIGITS_FIRST  = 3'd4;
    localparam logic [2:0] REG_DATE_DIGITS_SECOND = 3'd5;
    localparam logic [2:0] REG_DATE_DOTS_FIRST    = 3'd6;
    localparam logic [2:0] REG_DATE_DOTS_SECOND   = 3'd7;

    typedef struct packed {
        logic [1:0] op;
        logic       start_stop_pressed;
        logic       reset_pressed;
    } in_item_t;

    typedef struct packed {
        logic [7:0] segments;
        logic [3:0] digit_select;
        logic       running;
        logic       date_showing;
    } out_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] wrap_limit;
        logic [7:0]       blink_period;
        logic [7:0]       debounce_steps;
        logic [9:0]       date_phase_ticks;
        logic [15:0]      date_digits_first;
        logic [15:0]      date_digits_second;
        logic [3:0]       date_dots_first;
        logic [3:0]       date_dots_second;
    } cfg_t;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [7:0] residue;
    } res_load_t;

    typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

    function automatic logic [6:0] seg_code(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h3f;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5b;
            4'd3:    s = 7'h4f;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6d;
            4'd6:    s = 7'h7d;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7f;
            4'd9:    s = 7'h6f;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    // Digit 0 sits in the top nibble.
    function automatic digits_t pattern_digits(input logic [15:0] v);
        digits_t d;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            d[i] = v[15-4*i -: 4];
        end
        return d;
    endfunction

    // Digit 3 is the least significant decimal digit.
    function automatic digits_t bcd_inc(input digits_t v);
        digits_t d;
        logic    carry;
        d     = v;
        carry = 1'b1;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (carry) begin
                if (d[NUM_DIGITS-1-k] == 4'd9) begin
                    d[NUM_DIGITS-1-k] = 4'd0;
                end
                else begin
                    d[NUM_DIGITS-1-k] = d[NUM_DIGITS-1-k] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return d;
    endfunction

endpackage

// ----- src/stopwatch_seven_segment_mux.sv -----
// Four-digit centisecond stopwatch with a multiplexed seven-segment display.
// Input channel (in_valid/in_ready/in_data): one request per event: a 100 Hz
// tick, a 1 ms scan step that drives one digit and samples the buttons with
// digit 3, or a date request that shows two configured patterns in turn.
// Output channel (out_valid/out_ready/out_data): exactly one result per
// request with the latched segments, digit select, running and date flags.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// write only while no request is in flight.
// Each request is held in the input register until its result is pushed out.
// Throughput: one request per cycle unless a remainder runs or the buffer is full.
// A write of blink_period starts a serial remainder of the count;
// requests wait in the input register until it ends.
// Reset: count zero, watch stopped, display blank, configuration at defaults.
// Receiver stall: a two-entry output buffer takes results; when it is full
// the request in the input register holds and in_ready drops.
module stopwatch_seven_segment_mux
    import swssm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t             cfg_reg;
    logic             in_valid_reg;
    in_item_t         in_item_reg;
    logic             advance;
    logic             space;
    logic             cfg_write;
    res_load_t        res_load;
    logic [CNT_W-1:0] count;
    out_item_t        result;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;
    assign advance   = in_valid_reg & ~res_load.busy & space;
    assign in_ready  = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.wrap_limit         <= 14'd10000;
            cfg_reg.blink_period       <= 8'd50;
            cfg_reg.debounce_steps     <= 8'd200;
            cfg_reg.date_phase_ticks   <= 10'd500;
            cfg_reg.date_digits_first  <= 16'h0111;
            cfg_reg.date_digits_second <= 16'h1991;
            cfg_reg.date_dots_first    <= 4'd10;
            cfg_reg.date_dots_second   <= 4'd8;
        end
        else if (cfg_write) begin
            case (cfg_index)
                REG_WRAP_LIMIT:         cfg_reg.wrap_limit         <= cfg_data[CNT_W-1:0];
                REG_BLINK_PERIOD:       cfg_reg.blink_period       <= cfg_data[7:0];
                REG_DEBOUNCE_STEPS:     cfg_reg.debounce_steps     <= cfg_data[7:0];
                REG_DATE_PHASE_TICKS:   cfg_reg.date_phase_ticks   <= cfg_data[9:0];
                REG_DATE_DIGITS_FIRST:  cfg_reg.date_digits_first  <= cfg_data;
                REG_DATE_DIGITS_SECOND: cfg_reg.date_digits_second <= cfg_data;
                REG_DATE_DOTS_FIRST:    cfg_reg.date_dots_first    <= cfg_data[3:0];
                REG_DATE_DOTS_SECOND:   cfg_reg.date_dots_second   <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            in_item_reg <= in_data;
        end
    end

    swssm_res_div u_res_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cfg_write && cfg_index == REG_BLINK_PERIOD),
        .divisor  (cfg_data[7:0]),
        .count    (count),
        .res_load (res_load)
    );

    swssm_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (in_item_reg),
        .cfg      (cfg_reg),
        .res_load (res_load),
        .count    (count),
        .result   (result)
    );

    swssm_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_data (result),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `SWSSM_ASSERT_NEXT(a_take_after_full, clk, rst_n, in_valid && in_ready, in_valid_reg)

endmodule

// ----- src/swssm_res_div.sv -----
`include "stopwatch_seven_segment_mux_defines.svh"

module swssm_res_div
    import swssm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [7:0]       divisor,
    input  logic [CNT_W-1:0] count,
    output res_load_t        res_load
);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [3:0] idx_reg, idx_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] div_reg, div_next;
    logic [8:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, count[idx_reg]};
        if (start) begin
            div_next = divisor;
            rem_next = '0;
            idx_next = 4'(CNT_W - 1);
            if (divisor == 8'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = 8'(trial - {1'b0, div_reg});
            end
            else begin
                rem_next = trial[7:0];
            end
            idx_next = idx_reg - 4'd1;
            if (idx_reg == 4'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
            rem_reg  <= rem_next;
            div_reg  <= div_next;
        end
    end

    assign res_load.busy    = busy_reg | done_reg;
    assign res_load.done    = done_reg;
    assign res_load.residue = rem_reg;

    `SWSSM_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg && !start, !done_reg)
    `SWSSM_ASSERT_NOW(a_rem_below_div, clk, rst_n, busy_reg, rem_reg < div_reg)

endmodule

// ----- src/swssm_core.sv -----
`include "stopwatch_seven_segment_mux_defines.svh"

module swssm_core
    import swssm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  in_item_t         item,
    input  cfg_t             cfg,
    input  res_load_t        res_load,
    output logic [CNT_W-1:0] count,
    output out_item_t        result
);

    logic [CNT_W-1:0]      count_reg, count_next;
    digits_t               bcd_reg, bcd_next;
    logic [7:0]            res_reg, res_next;
    digits_t               shown_reg, shown_next;
    logic [NUM_DIGITS-1:0] dots_reg, dots_next;
    logic                  stopped_reg, stopped_next;
    logic [7:0]            debounce_reg, debounce_next;
    logic                  date_active_reg, date_active_next;
    logic [10:0]           date_ticks_reg, date_ticks_next;
    logic [1:0]            scan_reg, scan_next;
    logic [7:0]            seg_reg, seg_next;
    logic [NUM_DIGITS-1:0] sel_reg, sel_next;
    logic [10:0]           dt;
    logic [7:0]            res_inc;
    logic [7:0]            deb_dec;

    always_comb
    begin
        count_next       = count_reg;
        bcd_next         = bcd_reg;
        res_next         = res_reg;
        shown_next       = shown_reg;
        dots_next        = dots_reg;
        stopped_next     = stopped_reg;
        debounce_next    = debounce_reg;
        date_active_next = date_active_reg;
        date_ticks_next  = date_ticks_reg;
        scan_next        = scan_reg;
        seg_next         = seg_reg;
        sel_next         = sel_reg;
        dt               = date_ticks_reg + 11'd1;
        res_inc          = res_reg + 8'd1;
        deb_dec          = (debounce_reg != 8'd0) ? debounce_reg - 8'd1 : debounce_reg;

        if (res_load.done) begin
            res_next = res_load.residue;
        end

        if (advance) begin
            case (item.op)
                OP_TICK:
                begin
                    if (!stopped_reg) begin
                        if (count_reg >= cfg.wrap_limit) begin
                            count_next = '0;
                            bcd_next   = '0;
                            res_next   = '0;
                        end
                        else begin
                            count_next = count_reg + 14'd1;
                            bcd_next   = bcd_inc(bcd_reg);
                            res_next   = (res_inc == cfg.blink_period) ? 8'd0 : res_inc;
                        end
                        if (cfg.blink_period != 8'd0 && res_next == 8'd0) begin
                            dots_next[1] = ~dots_reg[1];
                        end
                        shown_next = bcd_next;
                    end
                    if (date_active_reg) begin
                        if (dt <= {1'b0, cfg.date_phase_ticks}) begin
                            date_ticks_next = dt;
                            shown_next      = pattern_digits(cfg.date_digits_first);
                            dots_next       = cfg.date_dots_first;
                        end
                        else if (dt <= {cfg.date_phase_ticks, 1'b0}) begin
                            date_ticks_next = dt;
                            shown_next      = pattern_digits(cfg.date_digits_second);
                            dots_next       = cfg.date_dots_second;
                        end
                        else begin
                            date_ticks_next  = '0;
                            date_active_next = 1'b0;
                        end
                    end
                end
                OP_SCAN:
                begin
                    seg_next      = {dots_reg[scan_reg], 7'(seg_code(shown_reg[scan_reg]))};
                    sel_next      = NUM_DIGITS'(1) << scan_reg;
                    debounce_next = deb_dec;
                    if (scan_reg == 2'(NUM_DIGITS - 1)) begin
                        if (deb_dec == 8'd0 && item.start_stop_pressed) begin
                            stopped_next  = ~stopped_reg;
                            debounce_next = cfg.debounce_steps;
                        end
                        else if (item.reset_pressed) begin
                            count_next = '0;
                            bcd_next   = '0;
                            res_next   = '0;
                            shown_next = '0;
                        end
                    end
                    scan_next = scan_reg + 2'd1;
                end
                OP_DATE:
                begin
                    date_active_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg       <= '0;
            bcd_reg         <= '0;
            res_reg         <= '0;
            shown_reg       <= '0;
            dots_reg        <= '0;
            stopped_reg     <= 1'b1;
            debounce_reg    <= '0;
            date_active_reg <= 1'b0;
            date_ticks_reg  <= '0;
            scan_reg        <= '0;
            seg_reg         <= '0;
            sel_reg         <= '0;
        end
        else begin
            count_reg       <= count_next;
            bcd_reg         <= bcd_next;
            res_reg         <= res_next;
            shown_reg       <= shown_next;
            dots_reg        <= dots_next;
            stopped_reg     <= stopped_next;
            debounce_reg    <= debounce_next;
            date_active_reg <= date_active_next;
            date_ticks_reg  <= date_ticks_next;
            scan_reg        <= scan_next;
            seg_reg         <= seg_next;
            sel_reg         <= sel_next;
        end
    end

    assign count               = count_reg;
    assign result.segments     = seg_next;
    assign result.digit_select = sel_next;
    assign result.running      = ~stopped_next;
    assign result.date_showing = date_active_next;

    `SWSSM_ASSERT_NOW(a_sel_onehot0, clk, rst_n, 1'b1, $onehot0(sel_reg))
    `SWSSM_ASSERT_NEXT(a_scan_drives, clk, rst_n, advance && item.op == OP_SCAN, sel_reg != '0)

endmodule

// ----- src/swssm_skid.sv -----
`include "stopwatch_seven_segment_mux_defines.svh"

module swssm_skid
    import swssm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_data,
    output logic      space,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    out_item_t  buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, rd_reg;
    logic       pop;

    assign pop       = out_valid & out_ready;
    assign space     = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = buf_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_reg <= ~wr_reg;
            end
            if (pop) begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            buf_reg[wr_reg] <= push_data;
        end
    end

    `SWSSM_ASSERT_NOW(a_no_overflow, clk, rst_n, 1'b1, cnt_reg != 2'd3)

endmodule
